/* src/lfo_waveform_generator_unit_defines.svh */
// ----------------------------------------------------------------------------
// LFO waveform generator assertion macros
// Shared concurrent assertion macros for the LFO waveform generator RTL.
// ----------------------------------------------------------------------------
`ifndef LFO_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH
`define LFO_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define LFOWG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfowg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFOWG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfowg assertion failed");

`else

`define LFOWG_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LFOWG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/lfowg_pkg.sv */
// ----------------------------------------------------------------------------
// LFO waveform generator package
// Shape codes, LFSR constants, pipeline stage type and small helper functions.
// ----------------------------------------------------------------------------
package lfowg_pkg;

    // Wave shape register codes.
    typedef enum logic [2:0] {
        SHAPE_SINE     = 3'd0,
        SHAPE_SQUARE   = 3'd1,
        SHAPE_SAW_UP   = 3'd2,
        SHAPE_SAW_DOWN = 3'd3,
        SHAPE_TRIANGLE = 3'd4,
        SHAPE_SAMPLE   = 3'd5
    } shape_t;

    localparam int unsigned SHAPE_W  = 3;
    localparam int unsigned STEP_W   = 24;
    localparam int unsigned WAVE_W   = 16;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned TDATA_W  = 24;

    // Galois LFSR for x^32 + x^22 + x^2 + x + 1.
    localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
    localparam logic [31:0] LFSR_SEED  = 32'h0000_0001;
    localparam int unsigned LFSR_STEPS = 16;

    // Fields that travel from the phase stage to the output stage.
    typedef struct packed {
        logic              is_sine;
        logic              negate;
        logic [WAVE_W-1:0] alt_value;
        logic              wrapped;
    } stage_t;

    // Advance the LFSR by sixteen shifts; this flattens to a small XOR network.
    function automatic logic [31:0] lfsr_advance(input logic [31:0] state);
        logic [31:0] s;
        s = state;
        for (int i = 0; i < LFSR_STEPS; i++) begin
            s = s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
        end
        return s;
    endfunction

    // Clamp an 18-bit signed value to the 16-bit signed range.
    function automatic logic [WAVE_W-1:0] sat16(input logic signed [17:0] v);
        logic [WAVE_W-1:0] r;
        if (v > 18'sd32767) begin
            r = 16'h7FFF;
        end
        else if (v < -18'sd32768) begin
            r = 16'h8000;
        end
        else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* src/lfo_waveform_generator_unit.sv */
// ----------------------------------------------------------------------------
// LFO waveform generator
// Phase-accumulator low-frequency oscillator with six selectable wave shapes.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_axis channel is one sample tick carrying a phase
//   step (fraction of a cycle). The step is added to a wrapping phase
//   accumulator and the oscillator answers with one request on the m_axis
//   channel: the Q1.15 wave sample and a flag that tells whether the phase
//   wrapped past a full cycle on that tick. A wrap also draws a new
//   sample-and-hold value from a 32-bit LFSR.
//   The wave shape is set through cfg_we / cfg_wdata while no tick is in
//   flight; it takes effect on the next tick.
// Pipeline and throughput:
//   The accepting edge registers the phase add and the shape arithmetic in the
//   phase stage; when the output register is free, the phase stage moves on
//   and the quarter-wave sine ROM is read into the output register, from
//   which m_axis presents the result. One request is taken every cycle as
//   long as the receiver keeps up.
// Reset and stalls:
//   Reset clears the phase to zero, the held random value to zero, seeds the
//   LFSR with one and selects the sine shape. When m_axis_tready is low the
//   output register holds its request, the phase stage fills behind it and
//   s_axis_tready then drops until the receiver takes the held result.
// ----------------------------------------------------------------------------
`include "lfo_waveform_generator_unit_defines.svh"

module lfo_waveform_generator_unit #(
    parameter int unsigned PHASE_BITS       = 24,
    parameter int unsigned SINE_TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    // Wave shape register write.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,

    // Input ticks. tdata: [23:0] phase_step.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,

    // Output samples. tdata: [15:0] wave_value, [16] cycle_wrapped, [23:17] zero.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata
);

    // Width of the ROM address; the table has SINE_TABLE_DEPTH + 1 entries.
    localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
    // Phase step bits that survive the mask to PHASE_BITS.
    localparam int unsigned USE_W  = (PHASE_BITS < lfowg_pkg::STEP_W) ?
                                     PHASE_BITS : lfowg_pkg::STEP_W;
    localparam int unsigned PROD_W = 14 + ADDR_W;

    // Architectural state.
    lfowg_pkg::shape_t       wave_shape_reg;
    logic [PHASE_BITS-1:0]   phase_acc_reg;
    logic [PHASE_BITS-1:0]   phase_acc_next;
    logic [15:0]             held_random_reg;
    logic [15:0]             held_random_next;
    logic [31:0]             noise_lfsr_reg;
    logic [31:0]             noise_lfsr_next;
    logic [31:0]             lfsr_step16;

    // Pipeline registers.
    logic                    s1_valid_reg;
    lfowg_pkg::stage_t       s1_stage_reg;
    lfowg_pkg::stage_t       s1_stage_next;
    logic [ADDR_W-1:0]       s1_addr_reg;
    logic [ADDR_W-1:0]       s1_addr_next;
    logic                    out_valid_reg;
    lfowg_pkg::stage_t       out_stage_reg;
    logic [14:0]             rom_q;

    // Handshake and advance controls.
    logic                    in_accept;
    logic                    out_free;
    logic                    s1_advance;

    // Phase stage arithmetic.
    logic [PHASE_BITS-1:0]   step_masked;
    logic [PHASE_BITS:0]     phase_sum;
    logic                    wrapped;
    logic [15:0]             frac;
    logic signed [17:0]      frac_s;
    logic [13:0]             quarter_pos;
    logic [PROD_W-1:0]       idx_prod;
    logic [ADDR_W-1:0]       idx;

    // Output assembly.
    logic [15:0]             sine_mag;
    logic [15:0]             wave_value;

    // ------------------------------------------------------------------------
    // Flow control: the output register is free when empty or being drained,
    // and the phase stage can take a new request whenever it is empty or can move on.
    // ------------------------------------------------------------------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_advance    = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------------
    // Phase accumulator and random draw.
    // ------------------------------------------------------------------------
    always_comb
    begin
        step_masked      = PHASE_BITS'(s_axis_tdata[USE_W-1:0]);
        phase_sum        = {1'b0, phase_acc_reg} + {1'b0, step_masked};
        wrapped          = phase_sum[PHASE_BITS];
        phase_acc_next   = phase_sum[PHASE_BITS-1:0];
        noise_lfsr_next  = wrapped ? lfsr_step16 : noise_lfsr_reg;
        held_random_next = wrapped ? lfsr_step16[31:16] : held_random_reg;
    end

    assign lfsr_step16 = lfowg_pkg::lfsr_advance(noise_lfsr_reg);

    // ------------------------------------------------------------------------
    // Shape arithmetic on the top 16 bits of the updated phase.
    // ------------------------------------------------------------------------
    always_comb
    begin
        frac        = phase_acc_next[PHASE_BITS-1 -: lfowg_pkg::FRAC_W];
        frac_s      = $signed({2'b00, frac});
        quarter_pos = frac[13:0];

        // Table index scaled from the position inside the quarter.
        idx_prod = PROD_W'(quarter_pos) * PROD_W'(SINE_TABLE_DEPTH);
        idx      = idx_prod[PROD_W-1:14];
        // Odd quadrants run the table backward.
        s1_addr_next = frac[14] ? (ADDR_W'(SINE_TABLE_DEPTH) - idx) : idx;

        s1_stage_next.is_sine   = 1'b0;
        s1_stage_next.negate    = frac[15];
        s1_stage_next.wrapped   = wrapped;
        s1_stage_next.alt_value = '0;

        case (wave_shape_reg)
            lfowg_pkg::SHAPE_SINE:
            begin
                s1_stage_next.is_sine = 1'b1;
            end
            lfowg_pkg::SHAPE_SQUARE:
            begin
                s1_stage_next.alt_value = frac[15] ? 16'h8000 : 16'h7FFF;
            end
            lfowg_pkg::SHAPE_SAW_UP:
            begin
                s1_stage_next.alt_value = {~frac[15], frac[14:0]};
            end
            lfowg_pkg::SHAPE_SAW_DOWN:
            begin
                s1_stage_next.alt_value = lfowg_pkg::sat16(18'sd32768 - frac_s);
            end
            lfowg_pkg::SHAPE_TRIANGLE:
            begin
                if (!frac[15])
                begin
                    s1_stage_next.alt_value = {~frac[14], frac[13:0], 1'b0};
                end
                else
                begin
                    s1_stage_next.alt_value =
                        lfowg_pkg::sat16(18'sd98304 - (frac_s <<< 1));
                end
            end
            lfowg_pkg::SHAPE_SAMPLE:
            begin
                s1_stage_next.alt_value = held_random_next;
            end
            default:
            begin
                s1_stage_next.alt_value = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Configuration and state registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_shape_reg  <= lfowg_pkg::SHAPE_SINE;
            phase_acc_reg   <= '0;
            held_random_reg <= '0;
            noise_lfsr_reg  <= lfowg_pkg::LFSR_SEED;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wave_shape_reg <= lfowg_pkg::shape_t'(cfg_wdata);
            end
            if (in_accept)
            begin
                phase_acc_reg   <= phase_acc_next;
                held_random_reg <= held_random_next;
                noise_lfsr_reg  <= noise_lfsr_next;
            end
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_stage_reg <= s1_stage_next;
            s1_addr_reg  <= s1_addr_next;
        end
        if (s1_advance)
        begin
            out_stage_reg <= s1_stage_reg;
        end
    end

    // The ROM output register loads together with out_stage_reg.
    lfowg_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk     (clk),
        .rd_en   (s1_advance),
        .rd_addr (s1_addr_reg),
        .rd_data (rom_q)
    );

    // ------------------------------------------------------------------------
    // Output: sine magnitude takes its quadrant sign, other shapes pass as is.
    // ------------------------------------------------------------------------
    always_comb
    begin
        sine_mag   = {1'b0, rom_q};
        wave_value = out_stage_reg.is_sine ?
                     (out_stage_reg.negate ? (16'd0 - sine_mag) : sine_mag) :
                     out_stage_reg.alt_value;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_stage_reg.wrapped, wave_value};

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // A stalled phase stage never takes a new request.
    `LFOWG_ASSERT_NOW(a_no_overrun, clk, rst_n, s1_valid_reg && !out_free, !s_axis_tready)
    // The LFSR never falls into the all-zero lock-up state.
    `LFOWG_ASSERT_NOW(a_lfsr_alive, clk, rst_n, 1'b1, noise_lfsr_reg != 32'd0)
    // Without a wrap the noise source and held value stay put.
    `LFOWG_ASSERT_NEXT(a_hold_no_wrap, clk, rst_n, in_accept && !wrapped,
        $stable(noise_lfsr_reg) && $stable(held_random_reg))
    // Without a wrap the phase only moves forward.
    `LFOWG_ASSERT_NEXT(a_phase_fwd, clk, rst_n, in_accept && !wrapped,
        phase_acc_reg >= $past(phase_acc_reg))
    // A result leaving the phase stage lands in the output register.
    `LFOWG_ASSERT_NEXT(a_stage_move, clk, rst_n, s1_advance, out_valid_reg)

endmodule

/* src/lfowg_sine_rom.sv */
// ----------------------------------------------------------------------------
// LFO quarter-wave sine ROM
// Quarter-wave table of DEPTH+1 magnitudes in Q1.15, with a registered read.
// ----------------------------------------------------------------------------
module lfowg_sine_rom #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH+1)-1:0]   rd_addr,
    output logic [14:0]                  rd_data
);

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ROUND_HALF  = 64'd536870912;

    typedef logic [14:0] rom_t [DEPTH+1];

    // One Horner step of the series: t = 1 - x2 * t / den, floored at zero.
    function automatic logic [63:0] horner_term(input logic [63:0] sub);
        return (sub >= Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
    endfunction

    // Entry k is round(32767 * sin(k * pi / (2 * DEPTH))) using a Q30 series.
    function automatic logic [14:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(k) * HALF_PI_Q30) / DEPTH;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = horner_term(((x2 * t) >> 30) / 156);
        t  = horner_term(((x2 * t) >> 30) / 110);
        t  = horner_term(((x2 * t) >> 30) / 72);
        t  = horner_term(((x2 * t) >> 30) / 42);
        t  = horner_term(((x2 * t) >> 30) / 20);
        t  = horner_term(((x2 * t) >> 30) / 6);
        s  = (x * t) >> 30;
        s  = (s * 64'd32767 + ROUND_HALF) >> 30;
        return (s > 64'd32767) ? 15'h7FFF : s[14:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int unsigned k = 0; k <= DEPTH; k++) begin
            r[k] = sine_entry(k);
        end
        return r;
    endfunction

    localparam rom_t ROM_DATA = build_rom();

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= ROM_DATA[rd_addr];
        end
    end

endmodule
